>>> hdl/keyword_substitution_cipher_core_macros.svh
// Assertion macros for the cipher core back end.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_CORE_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Checks that a property holds at every rising clock edge outside reset.
`define KWSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition is never true.
`define KWSC_ASSERT_NEVER(lbl, cond, msg) \
  `KWSC_ASSERT(lbl, !(cond), msg)
`else
`define KWSC_ASSERT(lbl, prop, msg)
`define KWSC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> hdl/kwsc_pkg.sv
package kwsc_pkg;

  // Alphabet geometry.
  localparam int unsigned LetterCount = 26;
  localparam int unsigned IdxW        = 5;

  typedef logic [IdxW-1:0]        idx_t;
  typedef logic [LetterCount-1:0] letter_set_t;

  // Index used for bytes that are not letters.
  localparam idx_t NoLetter   = idx_t'(LetterCount);
  localparam idx_t LastLetter = idx_t'(LetterCount - 1);

  // ASCII constants.
  localparam logic [7:0] UpperA  = 8'h41;
  localparam logic [7:0] UpperZ  = 8'h5A;
  localparam logic [7:0] LowerA  = 8'h61;
  localparam logic [7:0] LowerZ  = 8'h7A;
  localparam logic [7:0] CaseBit = 8'h20;

  // Command codes of an input transaction.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_KEY   = 2'd1,
    OP_TEXT  = 2'd2
  } op_e;

  // Classified item as it travels from the front end to the back end.
  typedef struct packed {
    op_e        op;
    idx_t       idx;
    logic       lower;
    logic [7:0] char_raw;
  } item_t;

  // Back end sequencer states.
  typedef enum logic {
    ST_RUN,
    ST_FILL
  } state_e;

  // Decoupling queue geometry.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);

endpackage

>>> hdl/kwsc_front.sv
module kwsc_front (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          char_in_i,
  input  logic                q_ready_i,
  output logic                q_push_o,
  output kwsc_pkg::item_t     q_item_o
);

  logic              is_upper;
  logic              is_lower;
  logic              keep;
  logic [7:0]        upper_off;
  logic [7:0]        lower_off;
  kwsc_pkg::idx_t    idx;

  // Letter classification of the incoming byte.
  assign is_upper  = (char_in_i >= kwsc_pkg::UpperA) && (char_in_i <= kwsc_pkg::UpperZ);
  assign is_lower  = (char_in_i >= kwsc_pkg::LowerA) && (char_in_i <= kwsc_pkg::LowerZ);
  assign upper_off = char_in_i - kwsc_pkg::UpperA;
  assign lower_off = char_in_i - kwsc_pkg::LowerA;

  always_comb begin
    if (is_upper) begin
      idx = upper_off[kwsc_pkg::IdxW-1:0];
    end else if (is_lower) begin
      idx = lower_off[kwsc_pkg::IdxW-1:0];
    end else begin
      idx = kwsc_pkg::NoLetter;
    end
  end

  // Unused command codes are accepted and dropped here.
  always_comb begin
    unique case (opcode_i) inside
      kwsc_pkg::OP_CLEAR, kwsc_pkg::OP_KEY, kwsc_pkg::OP_TEXT: keep = 1'b1;
      default:                                                keep = 1'b0;
    endcase
  end

  // Transactions are accepted whenever the queue has room.
  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i && keep;

  always_comb begin
    q_item_o.op       = kwsc_pkg::op_e'(opcode_i);
    q_item_o.idx      = idx;
    q_item_o.lower    = is_lower;
    q_item_o.char_raw = char_in_i;
  end

endmodule

>>> hdl/kwsc_queue.sv
module kwsc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  kwsc_pkg::item_t push_item_i,
  output logic            push_ready_o,
  input  logic            pop_i,
  output logic            pop_valid_o,
  output kwsc_pkg::item_t pop_item_o
);

  kwsc_pkg::item_t                mem_q [kwsc_pkg::QueueDepth];
  logic [kwsc_pkg::PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [kwsc_pkg::PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [kwsc_pkg::CountW-1:0]    count_q, count_d;
  logic                           do_push;
  logic                           do_pop;

  localparam logic [kwsc_pkg::PtrW-1:0] LastPtr =
    kwsc_pkg::PtrW'(kwsc_pkg::QueueDepth - 1);
  localparam logic [kwsc_pkg::CountW-1:0] FullCount =
    kwsc_pkg::CountW'(kwsc_pkg::QueueDepth);

  assign push_ready_o = (count_q != FullCount);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> hdl/kwsc_back.sv
`include "keyword_substitution_cipher_core_macros.svh"

module kwsc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            encrypt_mode_i,
  input  logic            q_valid_i,
  input  kwsc_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      char_out_o
);

  kwsc_pkg::state_e      state_q, state_d;
  kwsc_pkg::idx_t        fill_cnt_q, fill_cnt_d;
  logic                  complete_q, complete_d;
  kwsc_pkg::letter_set_t taken_q;
  kwsc_pkg::idx_t        key_len_q;
  kwsc_pkg::idx_t        cipher_q [kwsc_pkg::LetterCount];
  kwsc_pkg::idx_t        plain_q  [kwsc_pkg::LetterCount];
  logic                  out_valid_q;
  logic [7:0]            char_out_q;

  logic                  clear;
  logic                  place_req;
  logic                  place_fire;
  logic                  load_out;
  logic                  slot_free;
  logic                  sweeping;
  kwsc_pkg::idx_t        place_idx;
  kwsc_pkg::idx_t        mapped;
  kwsc_pkg::idx_t        wrapped;
  logic [7:0]            letter;
  logic [7:0]            result;

  localparam kwsc_pkg::idx_t FullKey = kwsc_pkg::idx_t'(kwsc_pkg::LetterCount);

  assign slot_free = !out_valid_q || out_ready_i;
  assign sweeping  = (state_q == kwsc_pkg::ST_FILL);

  // Sequencer: runs queued commands and sweeps Z down to A to finish the alphabet.
  always_comb begin
    state_d    = state_q;
    fill_cnt_d = fill_cnt_q;
    complete_d = complete_q;
    clear      = 1'b0;
    place_req  = 1'b0;
    q_pop_o    = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      kwsc_pkg::ST_RUN: begin
        if (q_valid_i) begin
          unique case (q_item_i.op)
            kwsc_pkg::OP_CLEAR: begin
              q_pop_o    = 1'b1;
              clear      = 1'b1;
              complete_d = 1'b0;
            end
            kwsc_pkg::OP_KEY: begin
              q_pop_o   = 1'b1;
              place_req = !complete_q;
            end
            kwsc_pkg::OP_TEXT: begin
              if (!complete_q) begin
                state_d    = kwsc_pkg::ST_FILL;
                fill_cnt_d = kwsc_pkg::LastLetter;
              end else if (slot_free) begin
                q_pop_o  = 1'b1;
                load_out = 1'b1;
              end
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      kwsc_pkg::ST_FILL: begin
        place_req = 1'b1;
        if (fill_cnt_q == '0) begin
          complete_d = 1'b1;
          state_d    = kwsc_pkg::ST_RUN;
        end else begin
          fill_cnt_d = fill_cnt_q - 1'b1;
        end
      end
      default: state_d = kwsc_pkg::ST_RUN;
    endcase
  end

  // A letter is placed only if it is new and the alphabet still has room.
  assign place_idx  = sweeping ? fill_cnt_q : q_item_i.idx;
  assign place_fire = place_req && (place_idx < FullKey) && (key_len_q < FullKey) &&
                      !taken_q[place_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kwsc_pkg::ST_RUN;
      fill_cnt_q <= '0;
      complete_q <= 1'b0;
      taken_q    <= '0;
      key_len_q  <= '0;
    end else begin
      state_q    <= state_d;
      fill_cnt_q <= fill_cnt_d;
      complete_q <= complete_d;
      if (clear) begin
        taken_q   <= '0;
        key_len_q <= '0;
      end else if (place_fire) begin
        taken_q[place_idx] <= 1'b1;
        key_len_q          <= key_len_q + 1'b1;
      end
    end
  end

  // Forward and inverse tables are written together.
  always_ff @(posedge clk_i) begin
    if (place_fire) begin
      cipher_q[key_len_q] <= place_idx;
      plain_q[place_idx]  <= key_len_q;
    end
  end

  // Table lookup and case restore for a text byte.
  assign mapped  = encrypt_mode_i ? cipher_q[q_item_i.idx] : plain_q[q_item_i.idx];
  assign wrapped = (mapped >= FullKey) ? mapped - FullKey : mapped;
  assign letter  = kwsc_pkg::UpperA + {3'b000, wrapped};

  always_comb begin
    if (q_item_i.idx < FullKey) begin
      result = q_item_i.lower ? (letter | kwsc_pkg::CaseBit) : letter;
    end else begin
      result = q_item_i.char_raw;
    end
  end

  // Output register decouples the result from the downstream stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      char_out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_out_q;

  `KWSC_ASSERT_NEVER(a_key_len_range, key_len_q > FullKey, "key length beyond alphabet size")
  `KWSC_ASSERT(a_taken_count, $countones(taken_q) == int'(key_len_q), "length and set differ")
  `KWSC_ASSERT(a_complete_full, complete_q |-> key_len_q == FullKey, "complete but not full")
  `KWSC_ASSERT(a_fill_no_pop, sweeping |-> !q_pop_o && !load_out, "queue popped during sweep")

endmodule

>>> hdl/keyword_substitution_cipher_core.sv
// Keyword substitution cipher core. Key transactions (opcode 1) append each
// new letter of the keyword, case folded, to the cipher alphabet; opcode 0
// clears the key. The first text transaction (opcode 2) after a clear or reset
// finishes the alphabet with the unused letters from Z down to A in a sweep,
// and then every text byte is enciphered or deciphered according to
// encrypt_mode, keeping its case; non-letters pass through. In steady state,
// while the output is not stalled, one text byte is accepted and one result
// delivered per cycle: a front end classifies the byte, a two-entry queue
// decouples it from the back end, and the back end does one table lookup per
// cycle into a registered output. Key and clear transactions return no result.
// encrypt_mode may be written only while no transaction is in flight.
module keyword_substitution_cipher_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  logic            encrypt_mode_q;
  logic            q_push;
  logic            q_ready;
  logic            q_pop;
  logic            q_valid;
  kwsc_pkg::item_t push_item;
  kwsc_pkg::item_t pop_item;

  // Mode register, enciphering after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encrypt_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      encrypt_mode_q <= cfg_wdata_i;
    end
  end

  kwsc_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .char_in_i  (char_in_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  kwsc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_item_i  (push_item),
    .push_ready_o (q_ready),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_item_o   (pop_item)
  );

  kwsc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .encrypt_mode_i (encrypt_mode_q),
    .q_valid_i      (q_valid),
    .q_item_i       (pop_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .char_out_o     (char_out_o)
  );

endmodule
